// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the Hammersley point generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define HPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define HPS_ASSERT_SAME(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define HPS_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`else

`define HPS_ASSERT(lbl, clk, rst, prop, msg)
`define HPS_ASSERT_SAME(lbl, clk, rst, cond, cons, msg)
`define HPS_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg)

`endif

`endif

// ===== hdl/hps_pkg.sv =====
// Types, widths and constant tables of the Hammersley point generator.
package hps_pkg;

   localparam int INDEX_BITS = 16;
   localparam int FRAC_BITS  = 32;
   localparam int MAX_DIMS   = 11;

   localparam int NPRIMES    = 10;
   localparam int BIDX_W     = $clog2(NPRIMES);
   localparam int BASE_W     = 5;
   localparam int DIM_W      = 4;
   localparam int NPTS_W     = 17;
   localparam int COORD_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Point index plus one, digit numerator and denominator widths.
   localparam int IDX_W      = INDEX_BITS + 1;
   localparam int DEN_W      = IDX_W + BASE_W;
   localparam int REM_W      = DEN_W + 1;
   localparam int CNT_W      = $clog2(FRAC_BITS);

   // Digit extraction divides by the base through a scaled reciprocal.
   localparam int RECIP_SHIFT = IDX_W + 1;
   localparam longint unsigned RECIP_SCALE = longint'(1) << RECIP_SHIFT;
   localparam int PROD_W     = IDX_W + RECIP_SHIFT;

   localparam logic [0:0] CSR_NUM_POINTS = 1'b0;
   localparam logic [0:0] CSR_NUM_DIMS   = 1'b1;

   localparam logic [NPTS_W-1:0] NUM_POINTS_RESET = NPTS_W'(1);
   localparam logic [DIM_W-1:0]  NUM_DIMS_RESET   = DIM_W'(2);

   localparam logic [BASE_W-1:0] PRIME [NPRIMES] = '{
      5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
   };

   localparam logic [RECIP_SHIFT-1:0] RECIP [NPRIMES] = '{
      RECIP_SHIFT'(RECIP_SCALE / 2),  RECIP_SHIFT'(RECIP_SCALE / 3),
      RECIP_SHIFT'(RECIP_SCALE / 5),  RECIP_SHIFT'(RECIP_SCALE / 7),
      RECIP_SHIFT'(RECIP_SCALE / 11), RECIP_SHIFT'(RECIP_SCALE / 13),
      RECIP_SHIFT'(RECIP_SCALE / 17), RECIP_SHIFT'(RECIP_SCALE / 19),
      RECIP_SHIFT'(RECIP_SCALE / 23), RECIP_SHIFT'(RECIP_SCALE / 29)
   };

   typedef struct packed {
      logic start;
      logic setup;
      logic dig_a;
      logic dig_b;
      logic div_step;
      logic emit;
   } hps_cmd_type;

   typedef struct packed {
      logic axis0;
      logic digits_done;
      logic last_dim;
      logic out_free;
   } hps_stat_type;

endpackage

// ===== hdl/hps_ctrl.sv =====
// Sequencer of the Hammersley point generator: steps each coordinate.
`include "assert_macros.svh"

module hps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hps_pkg::hps_stat_type stat,
   output hps_pkg::hps_cmd_type  cmd
);
   import hps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIG_A,
      ST_DIG_B,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] bit_cnt_ff;
   logic [CNT_W-1:0] bit_cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup  = 1'b1;
            bit_cnt_in = CNT_W'(FRAC_BITS - 1);
            state_in   = stat.axis0 ? ST_DIV : ST_DIG_A;
         end
         ST_DIG_A: begin
            cmd.dig_a = 1'b1;
            state_in  = ST_DIG_B;
         end
         ST_DIG_B: begin
            cmd.dig_b = 1'b1;
            state_in  = stat.digits_done ? ST_DIV : ST_DIG_A;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.last_dim ? ST_IDLE : ST_SETUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   `HPS_ASSERT_NEXT(a_start_to_setup, clock, reset, cmd.start, state_ff == ST_SETUP,
      "accepted request did not move to setup")
   `HPS_ASSERT_NEXT(a_div_end, clock, reset, state_ff == ST_DIV && bit_cnt_ff == '0,
      state_ff == ST_EMIT, "division did not end after the last quotient bit")
   `HPS_ASSERT_NEXT(a_digits_to_div, clock, reset, cmd.dig_b && stat.digits_done,
      state_ff == ST_DIV && bit_cnt_ff == CNT_W'(FRAC_BITS - 1),
      "division did not start with a full bit count")

endmodule

// ===== hdl/hps_datapath.sv =====
// Datapath of the Hammersley point generator: digits, division, result register.
`include "assert_macros.svh"

module hps_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  hps_pkg::hps_cmd_type            cmd,
   output hps_pkg::hps_stat_type           stat,
   input  logic [hps_pkg::NPTS_W-1:0]      num_points,
   input  logic [hps_pkg::DIM_W-1:0]       num_dims,
   input  logic [hps_pkg::INDEX_BITS-1:0]  req_point_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hps_pkg::DIM_W-1:0]       rsp_dim_index,
   output logic [hps_pkg::COORD_W-1:0]     rsp_coordinate,
   output logic                            rsp_last
);
   import hps_pkg::*;

   logic [INDEX_BITS-1:0]  p_ff;
   logic [DIM_W-1:0]       dims_ff;
   logic [DIM_W-1:0]       dim_ff;
   logic [IDX_W-1:0]       i_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [FRAC_BITS-1:0]   quot_ff;
   logic                   sat_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [DEN_W-1:0]       rb_ff;
   logic [DEN_W-1:0]       denb_ff;
   logic                   rsp_valid_ff;
   logic [DIM_W-1:0]       rsp_dim_ff;
   logic [COORD_W-1:0]     rsp_coord_ff;
   logic                   rsp_last_ff;

   logic [NPTS_W-1:0]      n_eff;
   logic [DIM_W-1:0]       dims_eff;
   logic [DIM_W-1:0]       dim_m1;
   logic [BIDX_W-1:0]      bidx;
   logic [BASE_W-1:0]      base;
   logic [IDX_W-1:0]       q_est;
   logic [IDX_W-1:0]       qb;
   logic [IDX_W-1:0]       r_est;
   logic                   corr;
   logic [IDX_W-1:0]       r_fix;
   logic [BASE_W-1:0]      digit;
   logic [IDX_W-1:0]       q_fix;
   logic [REM_W-1:0]       rem2;
   logic                   ge;
   logic [NPTS_W:0]        axis_num;
   logic [NPTS_W:0]        axis_den;
   logic [FRAC_BITS-1:0]   coord_val;

   // Zero counts act as one; dimension count saturates at its maximum.
   assign n_eff    = (num_points == '0) ? NPTS_W'(1) : num_points;
   assign dims_eff = (num_dims == '0) ? DIM_W'(1) :
                     (num_dims > DIM_W'(MAX_DIMS)) ? DIM_W'(MAX_DIMS) : num_dims;

   assign dim_m1 = dim_ff - DIM_W'(1);
   assign bidx   = (dim_m1 > DIM_W'(NPRIMES - 1)) ? BIDX_W'(NPRIMES - 1) : dim_m1[BIDX_W-1:0];
   assign base   = PRIME[bidx];

   // Quotient estimate from the reciprocal is at most one low.
   assign q_est = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign qb    = q_est * IDX_W'(base);
   assign r_est = i_ff - qb;
   assign corr  = (r_est >= IDX_W'(base));
   assign r_fix = corr ? (r_est - IDX_W'(base)) : r_est;
   assign digit = r_fix[BASE_W-1:0];
   assign q_fix = q_est + IDX_W'(corr);

   assign rem2 = {rem_ff[REM_W-2:0], 1'b0};
   assign ge   = (rem2 >= REM_W'(den_ff));

   assign axis_num = {1'b0, p_ff, 1'b1} ;
   assign axis_den = {n_eff, 1'b0};

   assign coord_val = sat_ff ? '1 : quot_ff;

   assign stat.axis0       = (dim_ff == '0);
   assign stat.digits_done = (q_fix == '0);
   assign stat.last_dim    = (dim_ff == dims_ff - DIM_W'(1));
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         p_ff    <= req_point_number;
         dims_ff <= dims_eff;
         dim_ff  <= '0;
      end else if (cmd.emit) begin
         dim_ff  <= dim_ff + DIM_W'(1);
      end

      if (cmd.setup) begin
         if (dim_ff == '0) begin
            rem_ff <= REM_W'(axis_num);
            den_ff <= DEN_W'(axis_den);
            sat_ff <= (axis_num >= axis_den);
         end else begin
            rem_ff <= '0;
            den_ff <= DEN_W'(1);
            sat_ff <= 1'b0;
         end
         i_ff <= IDX_W'(p_ff) + IDX_W'(1);
      end else if (cmd.dig_b) begin
         i_ff   <= q_fix;
         rem_ff <= REM_W'(rb_ff + DEN_W'(digit));
         den_ff <= denb_ff;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? (rem2 - REM_W'(den_ff)) : rem2;
         quot_ff <= {quot_ff[FRAC_BITS-2:0], ge};
      end

      if (cmd.dig_a) begin
         prod_ff <= PROD_W'(i_ff) * PROD_W'(RECIP[bidx]);
         rb_ff   <= rem_ff[DEN_W-1:0] * DEN_W'(base);
         denb_ff <= den_ff * DEN_W'(base);
      end

      if (cmd.emit) begin
         rsp_dim_ff   <= dim_ff;
         rsp_coord_ff <= COORD_W'(coord_val);
         rsp_last_ff  <= stat.last_dim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dim_index  = rsp_dim_ff;
   assign rsp_coordinate = rsp_coord_ff;
   assign rsp_last       = rsp_last_ff;

   `HPS_ASSERT_SAME(a_digit_range, clock, reset, cmd.dig_b, r_fix < IDX_W'(base),
      "corrected digit is not below the base")
   `HPS_ASSERT_SAME(a_div_precond, clock, reset, cmd.div_step && !sat_ff,
      rem_ff < REM_W'(den_ff), "division remainder reached the denominator")
   `HPS_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready,
      "result register loaded while its result was still pending")

endmodule

// ===== hdl/hammersley_point_generator.sv =====
// Top level of the Hammersley point generator: control registers and submodules.
//
// A request carries a point number p on req_point_number and is accepted when
// req_valid and req_ready are both high. The block answers with one result per
// dimension on the rsp_ channel, in dimension order, with rsp_last on the final
// one. Dimension 0 is (2p+1)/(2n); dimension d is the radical inverse of p+1 in
// the d-th prime base, all as unsigned 0.32 fractions, truncated.
// Each coordinate runs through one shared restoring divider, one quotient bit
// per cycle. Dimension 0 goes from setup straight to the division; dimension d
// first takes a DIG_A and a DIG_B step for each base digit of p+1. One point is
// worked on at a time; req_ready rises again as soon as the last result is
// loaded into the output register. If the receiver holds rsp_ready low, the
// finished result waits in the output register and the next coordinate is
// computed, then held until that register frees. Synchronous reset clears the
// sequencer and the output valid and sets num_points to 1 and num_dims to 2.
// Registers are written over the APB port at 0x0 (num_points) and 0x4
// (num_dims); the user must write them only while the block is idle, which the
// block itself does not enforce.
module hammersley_point_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [hps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [hps_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hps_pkg::INDEX_BITS-1:0]     req_point_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hps_pkg::DIM_W-1:0]          rsp_dim_index,
   output logic [hps_pkg::COORD_W-1:0]        rsp_coordinate,
   output logic                               rsp_last
);
   import hps_pkg::*;

   logic [NPTS_W-1:0] num_points_ff;
   logic [DIM_W-1:0]  num_dims_ff;
   logic              csr_wr;
   logic [0:0]        csr_index;
   hps_cmd_type       cmd;
   hps_stat_type      stat;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = paddr[2:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_POINTS_RESET;
         num_dims_ff   <= NUM_DIMS_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_NUM_POINTS: num_points_ff <= pwdata[NPTS_W-1:0];
            CSR_NUM_DIMS:   num_dims_ff   <= pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_NUM_POINTS: prdata = CSR_DATA_W'(num_points_ff);
         CSR_NUM_DIMS:   prdata = CSR_DATA_W'(num_dims_ff);
         default:        prdata = '0;
      endcase
   end

   hps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hps_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .num_points       (num_points_ff),
      .num_dims         (num_dims_ff),
      .req_point_number (req_point_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dim_index    (rsp_dim_index),
      .rsp_coordinate   (rsp_coordinate),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== dv/hammersley_point_generator_test.sv =====
// Self-checking testbench for the Hammersley point generator.
module hammersley_point_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hps_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 600;

   localparam logic [CSR_ADDR_W-1:0] ADDR_NUM_POINTS = {CSR_NUM_POINTS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_NUM_DIMS   = {CSR_NUM_DIMS, 2'b00};

   localparam int unsigned PRIME_BASES [NPRIMES] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

   typedef struct packed {
      logic [DIM_W-1:0]   dim;
      logic [COORD_W-1:0] value;
      logic               last;
   } coord_type;

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;
   logic                    req_valid;
   logic                    req_ready;
   logic [INDEX_BITS-1:0]   req_point_number;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b1;
   logic [DIM_W-1:0]        rsp_dim_index;
   logic [COORD_W-1:0]      rsp_coordinate;
   logic                    rsp_last;

   logic [NPTS_W-1:0]       cfg_points;
   logic [DIM_W-1:0]        cfg_dims;
   coord_type               expected_coords [$];
   int                      error_count = 0;
   int                      idle_cycles = 0;
   int                      stall_left = 0;
   bit                      gaps_on = 1'b1;
   bit                      stalls_on = 1'b1;

   hammersley_point_generator dut (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_number (req_point_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dim_index    (rsp_dim_index),
      .rsp_coordinate   (rsp_coordinate),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // floor(num * 2^FRAC_BITS / den) for num < den, one quotient bit per step.
   function automatic logic [COORD_W-1:0] fraction_bits(longint unsigned num,
                                                        longint unsigned den);
      longint unsigned rem;
      logic [COORD_W-1:0] q;
      rem = num;
      q = '0;
      for (int b = 0; b < FRAC_BITS; b++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // Digits of idx are mirrored about the radix point, giving rev / base^m exactly.
   function automatic logic [COORD_W-1:0] radical_inverse_bits(int unsigned idx,
                                                               int unsigned base);
      longint unsigned rev;
      longint unsigned den;
      int unsigned rest;
      rev = 0;
      den = 1;
      rest = idx;
      while (rest > 0) begin
         rev = rev * base + rest % base;
         den = den * base;
         rest = rest / base;
      end
      return fraction_bits(rev, den);
   endfunction

   function automatic void predict_point(logic [INDEX_BITS-1:0] p);
      int unsigned dims;
      longint unsigned n;
      longint unsigned num;
      longint unsigned den;
      coord_type c;
      n = (cfg_points == '0) ? 1 : longint'(cfg_points);
      dims = cfg_dims;
      if (dims == 0)
         dims = 1;
      if (dims > MAX_DIMS)
         dims = MAX_DIMS;
      for (int d = 0; d < dims; d++) begin
         c.dim = DIM_W'(d);
         if (d == 0) begin
            num = 2 * longint'(p) + 1;
            den = 2 * n;
            // A point outside the set would land at 1.0 or above, so it pins to all ones.
            c.value = (num >= den) ? '1 : fraction_bits(num, den);
         end else begin
            c.value = radical_inverse_bits(int'(p) + 1, PRIME_BASES[d - 1]);
         end
         c.last = (d + 1 == dims);
         expected_coords.push_back(c);
      end
   endfunction

   always @(posedge clock) begin : check_results
      coord_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_coords.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: dim %0d coordinate %h last %b", $time,
                     rsp_dim_index, rsp_coordinate, rsp_last);
         end else begin
            want = expected_coords.pop_front();
            if (rsp_dim_index !== want.dim) begin
               error_count++;
               $display("%0t: dim_index mismatch: expected %0d actual %0d", $time,
                        want.dim, rsp_dim_index);
            end
            if (rsp_coordinate !== want.value) begin
               error_count++;
               $display("%0t: coordinate mismatch on dim %0d: expected %h actual %h", $time,
                        want.dim, want.value, rsp_coordinate);
            end
            if (rsp_last !== want.last) begin
               error_count++;
               $display("%0t: last mismatch on dim %0d: expected %b actual %b", $time,
                        want.dim, want.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result back-pressure comes in bursts whose length is drawn at random.
   always @(negedge clock) begin
      if (reset || !stalls_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_point(input logic [INDEX_BITS-1:0] p);
      int unsigned k;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         k = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (k - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_point_number <= p;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_point(p);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_coords.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (addr == ADDR_NUM_POINTS)
         cfg_points = value[NPTS_W-1:0];
      else if (addr == ADDR_NUM_DIMS)
         cfg_dims = value[DIM_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_config(input int unsigned n, input int unsigned dims);
      drain_results();
      write_register(ADDR_NUM_POINTS, CSR_DATA_W'(n));
      write_register(ADDR_NUM_DIMS, CSR_DATA_W'(dims));
   endtask

   function automatic logic [INDEX_BITS-1:0] pick_point();
      if ($urandom_range(0, 7) == 0 || cfg_points > (1 << INDEX_BITS) || cfg_points == '0)
         return INDEX_BITS'($urandom);
      return INDEX_BITS'($urandom_range(0, cfg_points - 1));
   endfunction

   task automatic test_reset_values();
      send_point(16'd0);
      send_point(16'd1);
      send_point(16'hFFFF);
   endtask

   task automatic test_full_range();
      set_config(65536, 11);
      send_point(16'd0);
      send_point(16'd1);
      send_point(16'd2);
      send_point(16'd28);
      send_point(16'd32767);
      send_point(16'hFFFF);
   endtask

   task automatic test_clamped_settings();
      set_config(0, 0);
      send_point(16'd0);
      send_point(16'd1);
      set_config(131071, 12);
      send_point(16'hFFFF);
      set_config(7, 15);
      send_point(16'd6);
      send_point(16'd7);
      set_config(65536, 1);
      send_point(16'd40000);
   endtask

   task automatic test_random_points();
      int unsigned n;
      int unsigned dims;
      for (int phase = 0; phase < 4; phase++) begin
         gaps_on = (phase != 2);
         stalls_on = (phase != 2);
         case ($urandom_range(0, 3))
            0: n = $urandom_range(1, 16);
            1: n = $urandom_range(1, 65536);
            2: n = 65536;
            default: n = $urandom_range(0, 131071);
         endcase
         dims = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 11);
         set_config(n, dims);
         for (int i = 0; i < 20; i++) begin
            // Hold the sender back once until every coordinate has been drained.
            if (phase == 1 && i == 10)
               drain_results();
            send_point(pick_point());
         end
      end
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      set_config(65536, $urandom_range(1, 11));
      for (int i = 0; i < 20; i++)
         send_point(pick_point());
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_point_number = '0;
      cfg_points = NUM_POINTS_RESET;
      cfg_dims = NUM_DIMS_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_full_range();
      test_clamped_settings();
      test_random_points();
      test_back_to_back();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
